[sv/rgba_pixel_format_converter_defines.svh]
// Assertion macros for the RGBA pixel format converter.
`ifndef RGBA_PIXEL_FORMAT_CONVERTER_DEFINES_SVH
`define RGBA_PIXEL_FORMAT_CONVERTER_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, disabled during reset.
`define RPFC_ASSERT_IMP(label, clk_s, rst_s, ante, cons) \
  label: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
    else $error("rpfc: same-cycle check failed");
// Next-cycle implication, disabled during reset.
`define RPFC_ASSERT_NXT(label, clk_s, rst_s, ante, cons) \
  label: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
    else $error("rpfc: next-cycle check failed");
`else
`define RPFC_ASSERT_IMP(label, clk_s, rst_s, ante, cons)
`define RPFC_ASSERT_NXT(label, clk_s, rst_s, ante, cons)
`endif

`endif

[sv/rpfc_pkg.sv]
// Shared types and constants for the RGBA pixel format converter.
package rpfc_pkg;

  // Default largest row length in pixels
  localparam int unsigned MAX_WIDTH_DEF = 4096;

  // Fixed field widths
  localparam int unsigned CH_W     = 8;
  localparam int unsigned WORD_W   = 24;
  localparam int unsigned CFG_W    = 13;
  localparam int unsigned IDX_W    = 2;
  localparam int unsigned FMT_W    = 2;
  localparam int unsigned SUM_W    = 10;

  // Register indexes on the configuration port
  localparam logic [IDX_W-1:0] REG_OUTPUT_FORMAT    = 2'd0;
  localparam logic [IDX_W-1:0] REG_WHITE_BACKGROUND = 2'd1;
  localparam logic [IDX_W-1:0] REG_IMAGE_WIDTH      = 2'd2;

  // Mono thresholds: floor(sum/3) < 128 is the same as sum < 384
  localparam logic [CH_W-1:0]  MONO_ALPHA_MIN = 8'd128;
  localparam logic [SUM_W-1:0] DARK_SUM_LIMIT = 10'd384;
  localparam logic [CH_W-1:0]  CH_MAX         = 8'd255;

  // Position of the last bit in a mono byte
  localparam logic [2:0] MONO_LAST_POS = 3'd7;

  typedef enum logic [FMT_W-1:0] {
    FMT_RGB565 = 2'd0,
    FMT_RGB888 = 2'd1,
    FMT_MONO   = 2'd2,
    FMT_NONE   = 2'd3
  } fmt_t;

  // Configuration seen by the datapath
  typedef struct packed {
    fmt_t fmt;
    logic white;
  } cfg_t;

  // Per-pixel sequencing results
  typedef struct packed {
    logic            has_res;
    logic            last;
    logic [CH_W-1:0] mono_byte;
  } seq_out_t;

endpackage

[sv/rpfc_cfg_regs.sv]
// Configuration registers and row width clamp.
module rpfc_cfg_regs #(
  parameter int unsigned MAX_WIDTH = rpfc_pkg::MAX_WIDTH_DEF,
  parameter int unsigned LW        = 14
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [rpfc_pkg::IDX_W-1:0]  cfg_index,
  input  logic [rpfc_pkg::CFG_W-1:0]  cfg_wdata,
  output rpfc_pkg::cfg_t              cfg,
  output logic [LW-1:0]               width_m1
);
  import rpfc_pkg::*;

  fmt_t             fmt_r;
  logic             white_r;
  logic [CFG_W-1:0] width_r;
  logic [LW-1:0]    width_ext;
  logic [LW-1:0]    width_lim;

  // Store register writes; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_r   <= FMT_RGB565;
      white_r <= 1'b0;
      width_r <= CFG_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_OUTPUT_FORMAT:    fmt_r   <= fmt_t'(cfg_wdata[FMT_W-1:0]);
        REG_WHITE_BACKGROUND: white_r <= cfg_wdata[0];
        REG_IMAGE_WIDTH:      width_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Clamp width into 1..MAX_WIDTH
  always_comb begin
    width_ext = LW'(width_r);
    if (width_ext == '0) begin
      width_lim = LW'(1);
    end else if (width_ext > LW'(MAX_WIDTH)) begin
      width_lim = LW'(MAX_WIDTH);
    end else begin
      width_lim = width_ext;
    end
  end

  assign width_m1  = width_lim - LW'(1);
  assign cfg.fmt   = fmt_r;
  assign cfg.white = white_r;

endmodule

[sv/rpfc_pixel.sv]
// Per-pixel color conversion and mono threshold.
module rpfc_pixel (
  input  logic [rpfc_pkg::CH_W-1:0]   red,
  input  logic [rpfc_pkg::CH_W-1:0]   green,
  input  logic [rpfc_pkg::CH_W-1:0]   blue,
  input  logic [rpfc_pkg::CH_W-1:0]   alpha,
  input  rpfc_pkg::cfg_t              cfg,
  output logic [rpfc_pkg::WORD_W-1:0] color_word,
  output logic                        mono_bit
);
  import rpfc_pkg::*;

  logic [CH_W-1:0]  r_c;
  logic [CH_W-1:0]  g_c;
  logic [CH_W-1:0]  b_c;
  logic [SUM_W-1:0] sum;
  logic             dark;

  // floor(c*a/255) + (255-a); x/255 == (x + (x>>8) + 1) >> 8, x < 65535
  function automatic logic [CH_W-1:0] blend_white(input logic [CH_W-1:0] c,
                                                  input logic [CH_W-1:0] a);
    logic [2*CH_W-1:0] prod;
    logic [2*CH_W-1:0] adj;
    prod = (2*CH_W)'(c) * (2*CH_W)'(a);
    adj  = prod + (2*CH_W)'(prod[2*CH_W-1:CH_W]) + (2*CH_W)'(1);
    return adj[2*CH_W-1:CH_W] + (CH_MAX - a);
  endfunction

  // Composite over white when asked
  always_comb begin
    if (cfg.white) begin
      r_c = blend_white(red, alpha);
      g_c = blend_white(green, alpha);
      b_c = blend_white(blue, alpha);
    end else begin
      r_c = red;
      g_c = green;
      b_c = blue;
    end
  end

  // Pack RGB565 or RGB888
  always_comb begin
    if (cfg.fmt == FMT_RGB565) begin
      color_word = {8'b0, r_c[7:3], g_c[7:2], b_c[7:3]};
    end else begin
      color_word = {r_c, g_c, b_c};
    end
  end

  // Mono: dark when opaque enough and mean below mid gray
  assign sum      = SUM_W'(red) + SUM_W'(green) + SUM_W'(blue);
  assign dark     = (alpha > MONO_ALPHA_MIN) && (sum < DARK_SUM_LIMIT);
  assign mono_bit = cfg.white ? dark : !dark;

endmodule

[sv/rpfc_seq.sv]
// Column tracking and mono bit packing.
module rpfc_seq #(
  parameter int unsigned CW        = 12,
  parameter int unsigned LW        = 14
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               advance,
  input  logic               frame_start,
  input  logic               mono_bit,
  input  rpfc_pkg::cfg_t     cfg,
  input  logic [LW-1:0]      width_m1,
  output rpfc_pkg::seq_out_t seq
);
  import rpfc_pkg::*;

  logic [CW-1:0]   column_r;
  logic [CW-1:0]   column_nxt;
  logic [CH_W-1:0] acc_r;
  logic [CH_W-1:0] acc_nxt;
  logic [CW-1:0]   col;
  logic [CH_W-1:0] acc_base;
  logic [CH_W-1:0] acc_or;
  logic [2:0]      pos;
  logic            last;
  logic            mono_emit;

  // A frame start restarts the row and drops partial mono bits
  assign col      = frame_start ? '0 : column_r;
  assign acc_base = frame_start ? '0 : acc_r;
  assign pos      = col[2:0];
  assign last     = LW'(col) >= width_m1;
  assign acc_or   = acc_base | (CH_W'(mono_bit) << pos);
  assign mono_emit = (pos == MONO_LAST_POS) || last;

  // Next column and accumulator
  always_comb begin
    column_nxt = last ? '0 : col + CW'(1);
    if (cfg.fmt == FMT_MONO && !mono_emit) begin
      acc_nxt = acc_or;
    end else begin
      acc_nxt = '0;
    end
  end

  // Advance state when the pixel leaves the input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      column_r <= '0;
      acc_r    <= '0;
    end else if (advance) begin
      column_r <= column_nxt;
      acc_r    <= acc_nxt;
    end
  end

  // Result presence and mono byte
  always_comb begin
    unique case (cfg.fmt)
      FMT_RGB565, FMT_RGB888: seq.has_res = 1'b1;
      FMT_MONO:               seq.has_res = mono_emit;
      default:                seq.has_res = 1'b0;
    endcase
    seq.last      = last;
    seq.mono_byte = acc_or;
  end

endmodule

[sv/rgba_pixel_format_converter.sv]
// Top level of the RGBA pixel format converter.
// Converts one RGBA8888 pixel per clock to RGB565, RGB888 or packed mono
// bytes. Each accepted pixel passes an input register, one level of
// conversion logic (three 8x8 multiplies for white compositing) and the
// result register, which holds each result until taken; a new pixel is
// taken every clock while results are drained. Colour formats give one
// result per pixel; mono gives one byte per eight pixels or at the end of a
// row; format code three gives none. The column counter and mono accumulator
// update as a pixel leaves the input register, so a frame_start pixel restarts
// the row in order. Configuration must be written while idle; not enforced.
`include "rgba_pixel_format_converter_defines.svh"

module rgba_pixel_format_converter #(
  parameter int unsigned MAX_WIDTH = rpfc_pkg::MAX_WIDTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [rpfc_pkg::IDX_W-1:0]  cfg_index,
  input  logic [rpfc_pkg::CFG_W-1:0]  cfg_wdata,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [rpfc_pkg::CH_W-1:0]   in_red,
  input  logic [rpfc_pkg::CH_W-1:0]   in_green,
  input  logic [rpfc_pkg::CH_W-1:0]   in_blue,
  input  logic [rpfc_pkg::CH_W-1:0]   in_alpha,
  input  logic                        in_frame_start,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [rpfc_pkg::WORD_W-1:0] out_word,
  output logic                        out_row_end
);
  import rpfc_pkg::*;

  localparam int unsigned CW = $clog2(MAX_WIDTH);
  localparam int unsigned LW = ((CW > CFG_W) ? CW : CFG_W) + 1;

  cfg_t              cfg;
  logic [LW-1:0]     width_m1;
  seq_out_t          seq;
  logic [WORD_W-1:0] color_word;
  logic              mono_bit;

  logic              s1_v_r;
  logic [CH_W-1:0]   s1_red_r;
  logic [CH_W-1:0]   s1_green_r;
  logic [CH_W-1:0]   s1_blue_r;
  logic [CH_W-1:0]   s1_alpha_r;
  logic              s1_fs_r;
  logic              s1_go;
  logic              out_free;

  logic              out_valid_r;
  logic [WORD_W-1:0] out_word_r;
  logic              out_row_end_r;

  rpfc_cfg_regs #(
    .MAX_WIDTH (MAX_WIDTH),
    .LW        (LW)
  ) u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg),
    .width_m1  (width_m1)
  );

  rpfc_pixel u_pixel (
    .red        (s1_red_r),
    .green      (s1_green_r),
    .blue       (s1_blue_r),
    .alpha      (s1_alpha_r),
    .cfg        (cfg),
    .color_word (color_word),
    .mono_bit   (mono_bit)
  );

  rpfc_seq #(
    .CW        (CW),
    .LW        (LW)
  ) u_seq (
    .clk         (clk),
    .rst_n       (rst_n),
    .advance     (s1_go),
    .frame_start (s1_fs_r),
    .mono_bit    (mono_bit),
    .cfg         (cfg),
    .width_m1    (width_m1),
    .seq         (seq)
  );

  // Move the held pixel on when its result has room, or when it has none
  assign out_free = !out_valid_r || out_ready;
  assign s1_go    = s1_v_r && (!seq.has_res || out_free);
  assign in_ready = !s1_v_r || s1_go;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_ready) begin
      s1_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_red_r   <= in_red;
      s1_green_r <= in_green;
      s1_blue_r  <= in_blue;
      s1_alpha_r <= in_alpha;
      s1_fs_r    <= in_frame_start;
    end
  end

  // Result register: load on a new result, drop once the transaction completes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_go && seq.has_res) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && seq.has_res) begin
      out_word_r    <= (cfg.fmt == FMT_MONO) ? WORD_W'(seq.mono_byte) : color_word;
      out_row_end_r <= seq.last;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_word    = out_word_r;
  assign out_row_end = out_row_end_r;

  // Checks
  `RPFC_ASSERT_IMP(a_stall_blocks_input, clk, rst_n, s1_v_r && !s1_go, !in_ready)
  `RPFC_ASSERT_NXT(a_result_loaded, clk, rst_n, s1_go && seq.has_res, out_valid_r)
  `RPFC_ASSERT_IMP(a_color_always_result, clk, rst_n,
    s1_go && (cfg.fmt == FMT_RGB565 || cfg.fmt == FMT_RGB888), seq.has_res)

endmodule
